// ----- rtl/hfct_pkg.sv -----
package hfct_pkg;

    // Table geometry defaults
    localparam int TableSlotsDefault = 1024;
    localparam int ProbeLimitDefault = 16;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int CTX_W   = 48;
    localparam int POS_W   = 24;
    localparam int SLOT_W  = 10;
    localparam int CNT_W   = 32;
    localparam int DIST_W  = 50;
    localparam int HASH_W  = 32;

    // Hash multipliers and the context bits that feed the hash
    localparam logic [HASH_W-1:0] HASH_MUL_KEY = 32'd2654435761;
    localparam logic [HASH_W-1:0] HASH_MUL_CTX = 32'd40503;
    localparam int CTX_HASH_LO = 4;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD = 2'd0,
        CMD_READ   = 2'd1,
        CMD_TOTALS = 2'd2,
        CMD_NONE   = 2'd3
    } hfct_cmd_t;

    // Result status codes
    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_NEW     = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_READOUT = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic capture_rec;
        logic capture_read;
        logic totals;
        logic sum;
        logic check_rec;
        logic check_read;
        logic last_probe;
    } hfct_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic resolved;
        logic clear_last;
    } hfct_stat_t;

    // One table slot
    typedef struct packed {
        logic                     used;
        logic [KEY_W-1:0]         key;
        logic [CTX_W-1:0]         ctx;
        logic [CNT_W-1:0]         count;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
        logic [DIST_W-1:0]        min_dist;
        logic                     dist_known;
    } hfct_entry_t;

endpackage

// ----- rtl/hfct_ctrl.sv -----
module hfct_ctrl #(
    parameter int PROBE_LIMIT = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             command,
    input  hfct_pkg::hfct_stat_t   stat,
    output hfct_pkg::hfct_ctl_t    ctl,
    output logic                   busy
);
    import hfct_pkg::*;

    localparam int PC_W = $clog2(PROBE_LIMIT + 1);
    localparam logic [PC_W-1:0] LAST_PROBE = PC_W'(PROBE_LIMIT - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SUM,
        S_WAIT,
        S_CHECK
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] probe_reg, probe_next;
    logic            read_reg, read_next;

    // Decode state into datapath commands
    always_comb
    begin
        state_next = state_reg;
        probe_next = probe_reg;
        read_next  = read_reg;
        ctl        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear_step = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (hfct_cmd_t'(command))
                        CMD_RECORD:
                        begin
                            ctl.capture_rec = 1'b1;
                            read_next       = 1'b0;
                            state_next      = S_SUM;
                        end
                        CMD_READ:
                        begin
                            ctl.capture_read = 1'b1;
                            read_next        = 1'b1;
                            state_next       = S_WAIT;
                        end
                        CMD_TOTALS:
                            ctl.totals = 1'b1;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_SUM:
            begin
                ctl.sum    = 1'b1;
                probe_next = '0;
                state_next = S_WAIT;
            end
            S_WAIT:
                state_next = S_CHECK;
            S_CHECK:
            begin
                if (read_reg)
                begin
                    ctl.check_read = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctl.check_rec  = 1'b1;
                    ctl.last_probe = (probe_reg == LAST_PROBE);
                    if (stat.resolved || ctl.last_probe)
                        state_next = S_IDLE;
                    else
                    begin
                        probe_next = probe_reg + 1'b1;
                        state_next = S_WAIT;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            probe_reg <= '0;
            read_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            probe_reg <= probe_next;
            read_reg  <= read_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/hfct_dp.sv -----
module hfct_dp #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  hfct_pkg::hfct_ctl_t                    ctl,
    output hfct_pkg::hfct_stat_t                   stat,
    input  logic [hfct_pkg::KEY_W-1:0]             key,
    input  logic [hfct_pkg::CTX_W-1:0]             context_id,
    input  logic signed [hfct_pkg::POS_W-1:0]      pos_x,
    input  logic signed [hfct_pkg::POS_W-1:0]      pos_y,
    input  logic signed [hfct_pkg::POS_W-1:0]      pos_z,
    input  logic                                   camera_valid,
    input  logic signed [hfct_pkg::POS_W-1:0]      camera_x,
    input  logic signed [hfct_pkg::POS_W-1:0]      camera_y,
    input  logic signed [hfct_pkg::POS_W-1:0]      camera_z,
    input  logic [hfct_pkg::SLOT_W-1:0]            slot_index,
    output logic                                   done,
    output logic [1:0]                             status,
    output logic                                   entry_valid,
    output logic [hfct_pkg::KEY_W-1:0]             entry_key,
    output logic [hfct_pkg::CTX_W-1:0]             entry_context,
    output logic [hfct_pkg::CNT_W-1:0]             entry_count,
    output logic signed [hfct_pkg::POS_W-1:0]      last_x,
    output logic signed [hfct_pkg::POS_W-1:0]      last_y,
    output logic signed [hfct_pkg::POS_W-1:0]      last_z,
    output logic [hfct_pkg::DIST_W-1:0]            closest_dist_sq,
    output logic                                   dist_known,
    output logic [hfct_pkg::CNT_W-1:0]             total_calls,
    output logic [hfct_pkg::CNT_W-1:0]             dropped_calls
);
    import hfct_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    hfct_entry_t mem [TABLE_SLOTS];

    // Captured item
    logic [KEY_W-1:0]        key_reg;
    logic [CTX_W-1:0]        ctx_reg;
    logic signed [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic                    cam_reg;
    logic [HASH_W-1:0]       hk_reg, hc_reg;
    logic [DIST_W-1:0]       sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    range_reg;
    logic [CNT_W-1:0]        calls_reg, drops_reg;
    hfct_entry_t             rd_reg;

    // Result registers
    logic                    done_reg, done_next;
    logic [1:0]              status_reg, status_next;
    hfct_entry_t             res_reg, res_next;
    logic [CNT_W-1:0]        tcalls_reg, tcalls_next;
    logic [CNT_W-1:0]        tdrops_reg, tdrops_next;

    // Capture-time arithmetic on the ports
    logic signed [POS_W:0]    dx, dy, dz;
    logic signed [DIST_W-1:0] sqx, sqy, sqz;
    logic [HASH_W-1:0]        hk, hc;
    logic [31:0]              si_ext;

    always_comb
    begin
        dx     = {pos_x[POS_W-1], pos_x} - {camera_x[POS_W-1], camera_x};
        dy     = {pos_y[POS_W-1], pos_y} - {camera_y[POS_W-1], camera_y};
        dz     = {pos_z[POS_W-1], pos_z} - {camera_z[POS_W-1], camera_z};
        sqx    = dx * dx;
        sqy    = dy * dy;
        sqz    = dz * dz;
        hk     = key * HASH_MUL_KEY;
        hc     = context_id[CTX_HASH_LO +: HASH_W] * HASH_MUL_CTX;
        si_ext = 32'(slot_index);
    end

    // Probe compare against the slot just read
    logic        match, resolved;
    hfct_entry_t wr_data;
    logic        wr_en;
    logic [HASH_W-1:0] hash;

    assign hash     = hk_reg ^ hc_reg;
    assign match    = rd_reg.used && (rd_reg.key == key_reg) && (rd_reg.ctx == ctx_reg);
    assign resolved = !rd_reg.used || match;
    assign stat.resolved   = resolved;
    assign stat.clear_last = (idx_reg == IDX_LAST);

    // Build the slot write and the result
    always_comb
    begin
        wr_en       = 1'b0;
        wr_data     = rd_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        res_next    = res_reg;
        tcalls_next = tcalls_reg;
        tdrops_next = tdrops_reg;
        if (ctl.clear_step)
        begin
            wr_en    = 1'b1;
            wr_data  = '0;
            idx_next = idx_reg + 1'b1;
        end
        if (ctl.capture_read)
            idx_next = si_ext[IDX_W-1:0];
        if (ctl.sum)
            idx_next = hash[IDX_W-1:0];
        if (ctl.check_rec)
        begin
            if (match)
            begin
                wr_en = 1'b1;
                if (rd_reg.count != CNT_MAX)
                    wr_data.count = rd_reg.count + 1'b1;
                wr_data.px = px_reg;
                wr_data.py = py_reg;
                wr_data.pz = pz_reg;
                if (cam_reg && (!rd_reg.dist_known || dist_reg < rd_reg.min_dist))
                begin
                    wr_data.min_dist   = dist_reg;
                    wr_data.dist_known = 1'b1;
                end
            end
            else if (!rd_reg.used)
            begin
                wr_en              = 1'b1;
                wr_data.used       = 1'b1;
                wr_data.key        = key_reg;
                wr_data.ctx        = ctx_reg;
                wr_data.count      = CNT_W'(1);
                wr_data.px         = px_reg;
                wr_data.py         = py_reg;
                wr_data.pz         = pz_reg;
                wr_data.min_dist   = dist_reg;
                wr_data.dist_known = cam_reg;
            end
            if (resolved || ctl.last_probe)
            begin
                done_next   = 1'b1;
                status_next = match ? ST_COUNTED : (resolved ? ST_NEW : ST_DROPPED);
                res_next    = '0;
                tcalls_next = '0;
                tdrops_next = '0;
            end
            else
                idx_next = idx_reg + 1'b1;
        end
        if (ctl.check_read)
        begin
            done_next   = 1'b1;
            status_next = ST_READOUT;
            tcalls_next = '0;
            tdrops_next = '0;
            res_next    = '0;
            if (range_reg && rd_reg.used)
            begin
                res_next      = rd_reg;
                wr_en         = 1'b1;
                wr_data.used  = 1'b0;
                wr_data.count = '0;
            end
        end
        if (ctl.totals)
        begin
            done_next   = 1'b1;
            status_next = ST_READOUT;
            res_next    = '0;
            tcalls_next = calls_reg;
            tdrops_next = drops_reg;
        end
    end

    // Table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[idx_reg] <= wr_data;
        rd_reg <= mem[idx_reg];
    end

    // Capture item and hash products, sum the distance, register the result
    always_ff @(posedge clk)
    begin
        if (ctl.capture_rec)
        begin
            key_reg <= key;
            ctx_reg <= context_id;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            pz_reg  <= pos_z;
            cam_reg <= camera_valid;
            hk_reg  <= hk;
            hc_reg  <= hc;
            sqx_reg <= sqx;
            sqy_reg <= sqy;
            sqz_reg <= sqz;
        end
        if (ctl.capture_read)
            range_reg <= (si_ext < 32'(TABLE_SLOTS));
        if (ctl.sum)
            dist_reg <= cam_reg ? (sqx_reg + sqy_reg + sqz_reg) : '0;
        status_reg <= status_next;
        res_reg    <= res_next;
        tcalls_reg <= tcalls_next;
        tdrops_reg <= tdrops_next;
    end

    // Advance slot index, counters and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            calls_reg <= '0;
            drops_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            done_reg <= done_next;
            if (ctl.totals)
            begin
                calls_reg <= '0;
                drops_reg <= '0;
            end
            else
            begin
                if (ctl.capture_rec && calls_reg != CNT_MAX)
                    calls_reg <= calls_reg + 1'b1;
                if (ctl.check_rec && !resolved && ctl.last_probe && drops_reg != CNT_MAX)
                    drops_reg <= drops_reg + 1'b1;
            end
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign entry_valid     = res_reg.used;
    assign entry_key       = res_reg.key;
    assign entry_context   = res_reg.ctx;
    assign entry_count     = res_reg.count;
    assign last_x          = res_reg.px;
    assign last_y          = res_reg.py;
    assign last_z          = res_reg.pz;
    assign closest_dist_sq = res_reg.min_dist;
    assign dist_known      = res_reg.dist_known;
    assign total_calls     = tcalls_reg;
    assign dropped_calls   = tdrops_reg;

endmodule

// ----- rtl/hashed_flow_count_table.sv -----
// Counts (key, context_id) pairs in a linearly probed hash table. Issue a
// command by raising start while busy is low; each record, slot read or
// totals read returns one result on done for a single cycle, and the
// receiver must take it then, since the block cannot be held off. Command 3
// is taken and ignored. A totals read answers in the cycle after the
// transfer, with no busy time. A slot read passes through a wait state and
// a check state. A record first sums, then spends a wait and a check state
// on each slot probed (1 to PROBE_LIMIT); each probe waits on the registered
// read of the single-port table. After reset the block stays busy while it
// clears the table slot by slot. TABLE_SLOTS must be a power of two.
module hashed_flow_count_table #(
    parameter int TABLE_SLOTS = hfct_pkg::TableSlotsDefault,
    parameter int PROBE_LIMIT = hfct_pkg::ProbeLimitDefault
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [hfct_pkg::CMD_W-1:0]             command,
    input  logic [hfct_pkg::KEY_W-1:0]             key,
    input  logic [hfct_pkg::CTX_W-1:0]             context_id,
    input  logic signed [hfct_pkg::POS_W-1:0]      pos_x,
    input  logic signed [hfct_pkg::POS_W-1:0]      pos_y,
    input  logic signed [hfct_pkg::POS_W-1:0]      pos_z,
    input  logic                                   camera_valid,
    input  logic signed [hfct_pkg::POS_W-1:0]      camera_x,
    input  logic signed [hfct_pkg::POS_W-1:0]      camera_y,
    input  logic signed [hfct_pkg::POS_W-1:0]      camera_z,
    input  logic [hfct_pkg::SLOT_W-1:0]            slot_index,
    output logic                                   done,
    output logic [1:0]                             status,
    output logic                                   entry_valid,
    output logic [hfct_pkg::KEY_W-1:0]             entry_key,
    output logic [hfct_pkg::CTX_W-1:0]             entry_context,
    output logic [hfct_pkg::CNT_W-1:0]             entry_count,
    output logic signed [hfct_pkg::POS_W-1:0]      last_x,
    output logic signed [hfct_pkg::POS_W-1:0]      last_y,
    output logic signed [hfct_pkg::POS_W-1:0]      last_z,
    output logic [hfct_pkg::DIST_W-1:0]            closest_dist_sq,
    output logic                                   dist_known,
    output logic [hfct_pkg::CNT_W-1:0]             total_calls,
    output logic [hfct_pkg::CNT_W-1:0]             dropped_calls
);
    import hfct_pkg::*;

    hfct_ctl_t  ctl;
    hfct_stat_t stat;

    hfct_ctrl #(
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy)
    );

    hfct_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .stat            (stat),
        .key             (key),
        .context_id      (context_id),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .camera_valid    (camera_valid),
        .camera_x        (camera_x),
        .camera_y        (camera_y),
        .camera_z        (camera_z),
        .slot_index      (slot_index),
        .done            (done),
        .status          (status),
        .entry_valid     (entry_valid),
        .entry_key       (entry_key),
        .entry_context   (entry_context),
        .entry_count     (entry_count),
        .last_x          (last_x),
        .last_y          (last_y),
        .last_z          (last_z),
        .closest_dist_sq (closest_dist_sq),
        .dist_known      (dist_known),
        .total_calls     (total_calls),
        .dropped_calls   (dropped_calls)
    );

    // A result always lands while the block is idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // An ignored command gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_NONE) |=> !done)
        else $error("result after ignored command");

    // A totals transfer answers on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_TOTALS) |=> (done && status == ST_READOUT))
        else $error("totals result missing");

    // Only a record result can report a drop
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_DROPPED) |-> (total_calls == '0 && !entry_valid))
        else $error("drop result carries readout fields");

endmodule

// ----- sim/hashed_flow_count_table_checker.sv -----
module hashed_flow_count_table_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [hfct_pkg::CMD_W-1:0]         command,
    input  logic [hfct_pkg::KEY_W-1:0]         key,
    input  logic [hfct_pkg::CTX_W-1:0]         context_id,
    input  logic signed [hfct_pkg::POS_W-1:0]  pos_x,
    input  logic signed [hfct_pkg::POS_W-1:0]  pos_y,
    input  logic signed [hfct_pkg::POS_W-1:0]  pos_z,
    input  logic                               camera_valid,
    input  logic signed [hfct_pkg::POS_W-1:0]  camera_x,
    input  logic signed [hfct_pkg::POS_W-1:0]  camera_y,
    input  logic signed [hfct_pkg::POS_W-1:0]  camera_z,
    input  logic [hfct_pkg::SLOT_W-1:0]        slot_index,
    input  logic                               done,
    input  logic [1:0]                         status,
    input  logic                               entry_valid,
    input  logic [hfct_pkg::KEY_W-1:0]         entry_key,
    input  logic [hfct_pkg::CTX_W-1:0]         entry_context,
    input  logic [hfct_pkg::CNT_W-1:0]         entry_count,
    input  logic signed [hfct_pkg::POS_W-1:0]  last_x,
    input  logic signed [hfct_pkg::POS_W-1:0]  last_y,
    input  logic signed [hfct_pkg::POS_W-1:0]  last_z,
    input  logic [hfct_pkg::DIST_W-1:0]        closest_dist_sq,
    input  logic                               dist_known,
    input  logic [hfct_pkg::CNT_W-1:0]         total_calls,
    input  logic [hfct_pkg::CNT_W-1:0]         dropped_calls,
    output int                                 fail_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hfct_pkg::*;

    localparam int SLOTS = TableSlotsDefault;
    localparam int PROBES = ProbeLimitDefault;

    typedef struct packed {
        logic [1:0]              status;
        logic                    entry_valid;
        logic [KEY_W-1:0]        entry_key;
        logic [CTX_W-1:0]        entry_context;
        logic [CNT_W-1:0]        entry_count;
        logic [POS_W-1:0]        last_x;
        logic [POS_W-1:0]        last_y;
        logic [POS_W-1:0]        last_z;
        logic [DIST_W-1:0]       closest_dist_sq;
        logic                    dist_known;
        logic [CNT_W-1:0]        total_calls;
        logic [CNT_W-1:0]        dropped_calls;
    } flow_result_t;

    hfct_entry_t   flow_table [SLOTS];
    logic [CNT_W-1:0] calls_seen;
    logic [CNT_W-1:0] drops_seen;
    flow_result_t  awaited_results [$];

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [DIST_W-1:0] axis_sq(logic signed [POS_W-1:0] a,
                                                  logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic [POS_W:0] m;
        d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
        m = d[POS_W] ? -d : d;
        return DIST_W'(m) * DIST_W'(m);
    endfunction

    // Compute the result of one accepted command and update the table copy
    function automatic flow_result_t count_flow(hfct_cmd_t cmd);
        flow_result_t r;
        logic [HASH_W-1:0] h;
        logic [DIST_W-1:0] cam_dist;
        int idx;
        bit resolved;
        r = '0;
        if (cmd == CMD_RECORD) begin
            calls_seen = bump(calls_seen);
            cam_dist = camera_valid ? axis_sq(pos_x, camera_x) + axis_sq(pos_y, camera_y)
                                    + axis_sq(pos_z, camera_z) : '0;
            h = (key * HASH_MUL_KEY) ^ (context_id[CTX_HASH_LO +: HASH_W] * HASH_MUL_CTX);
            idx = h % SLOTS;
            resolved = 0;
            for (int i = 0; i < PROBES && !resolved; i++) begin
                if (flow_table[idx].used) begin
                    if (flow_table[idx].key == key && flow_table[idx].ctx == context_id) begin
                        flow_table[idx].count = bump(flow_table[idx].count);
                        flow_table[idx].px = pos_x;
                        flow_table[idx].py = pos_y;
                        flow_table[idx].pz = pos_z;
                        if (camera_valid && (!flow_table[idx].dist_known
                                || cam_dist < flow_table[idx].min_dist)) begin
                            flow_table[idx].min_dist = cam_dist;
                            flow_table[idx].dist_known = 1'b1;
                        end
                        r.status = ST_COUNTED;
                        resolved = 1;
                    end
                end else begin
                    flow_table[idx] = '{1'b1, key, context_id, 32'd1, pos_x, pos_y, pos_z,
                                        cam_dist, camera_valid};
                    r.status = ST_NEW;
                    resolved = 1;
                end
                idx = (idx + 1) % SLOTS;
            end
            if (!resolved) begin
                drops_seen = bump(drops_seen);
                r.status = ST_DROPPED;
            end
        end else if (cmd == CMD_READ) begin
            r.status = ST_READOUT;
            if (slot_index < SLOTS && flow_table[slot_index].used) begin
                r.entry_valid = 1'b1;
                r.entry_key = flow_table[slot_index].key;
                r.entry_context = flow_table[slot_index].ctx;
                r.entry_count = flow_table[slot_index].count;
                r.last_x = flow_table[slot_index].px;
                r.last_y = flow_table[slot_index].py;
                r.last_z = flow_table[slot_index].pz;
                r.closest_dist_sq = flow_table[slot_index].min_dist;
                r.dist_known = flow_table[slot_index].dist_known;
                flow_table[slot_index].used = 1'b0;
                flow_table[slot_index].count = '0;
            end
        end else begin
            r.status = ST_READOUT;
            r.total_calls = calls_seen;
            r.dropped_calls = drops_seen;
            calls_seen = '0;
            drops_seen = '0;
        end
        return r;
    endfunction

    // Predict on each command transfer other than command 3, compare on each strobe
    always @(posedge clk or negedge rst_n) begin
        flow_result_t seen;
        flow_result_t want;
        if (!rst_n) begin
            foreach (flow_table[i]) flow_table[i] = '0;
            calls_seen = '0;
            drops_seen = '0;
            awaited_results.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (done) begin
                seen = '{status, entry_valid, entry_key, entry_context, entry_count, last_x,
                         last_y, last_z, closest_dist_sq, dist_known, total_calls,
                         dropped_calls};
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result %h", $realtime, seen);
                end else begin
                    want = awaited_results.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch expected %h actual %h", $realtime,
                                     want, seen);
                    end
                end
            end
            if (start && !busy && hfct_cmd_t'(command) != CMD_NONE)
                awaited_results.push_back(count_flow(hfct_cmd_t'(command)));
            pending = awaited_results.size();
        end
    end
endmodule

// ----- sim/hashed_flow_count_table_test.sv -----
module hashed_flow_count_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hfct_pkg::*;

    logic clk, rst_n, start, busy, done, camera_valid, entry_valid, dist_known;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key, entry_key;
    logic [CTX_W-1:0] context_id, entry_context;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z, camera_x, camera_y, camera_z;
    logic signed [POS_W-1:0] last_x, last_y, last_z;
    logic [SLOT_W-1:0] slot_index;
    logic [1:0] status;
    logic [CNT_W-1:0] entry_count, total_calls, dropped_calls;
    logic [DIST_W-1:0] closest_dist_sq;
    int fail_count, pending;

    // Small pools of flows so records hit, collide and fill probe chains
    logic [KEY_W-1:0] key_pool [8];
    logic [CTX_W-1:0] ctx_pool [8];

    hashed_flow_count_table DUT (.*);
    hashed_flow_count_table_checker checker_i (.*);

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("hashed_flow_count_table_test failed");
        $finish;
    end

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return POS_W'($urandom_range(0, 64)) - 24'sd32;
            default: return POS_W'($urandom);
        endcase
    endfunction

    // Drive one command and hold it until the block takes the transfer
    task automatic issue(hfct_cmd_t cmd, logic [KEY_W-1:0] k, logic [CTX_W-1:0] c,
                         logic [SLOT_W-1:0] s);
        start <= 1'b1;
        command <= cmd;
        key <= k;
        context_id <= c;
        slot_index <= s;
        pos_x <= rand_pos();
        pos_y <= rand_pos();
        pos_z <= rand_pos();
        camera_valid <= 1'($urandom_range(0, 1));
        camera_x <= rand_pos();
        camera_y <= rand_pos();
        camera_z <= rand_pos();
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic rest(int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            issue(CMD_RECORD, key_pool[$urandom_range(0, 7)], ctx_pool[$urandom_range(0, 7)],
                  '0);
        else if (r < 76)
            issue(CMD_RECORD, $urandom, CTX_W'({$urandom, $urandom}), '0);
        else if (r < 92)
            issue(CMD_READ, '0, '0, SLOT_W'($urandom));
        else if (r < 97)
            issue(CMD_TOTALS, '0, '0, '0);
        else
            issue(CMD_NONE, $urandom, CTX_W'({$urandom, $urandom}), SLOT_W'($urandom));
    endtask

    initial
    begin
        int burst;
        start = 1'b0;
        command = CMD_NONE;
        key = '0;
        context_id = '0;
        {pos_x, pos_y, pos_z, camera_x, camera_y, camera_z} = '0;
        camera_valid = 1'b0;
        slot_index = '0;
        rst_n = 1'b0;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        foreach (ctx_pool[i]) ctx_pool[i] = CTX_W'({$urandom, $urandom});
        key_pool[0] = '1;
        ctx_pool[0] = '1;
        key_pool[1] = '0;
        ctx_pool[1] = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, repeat hits, a full probe chain, reads, totals, ignored command
        issue(CMD_TOTALS, '0, '0, '0);
        issue(CMD_RECORD, '1, '1, '0);
        issue(CMD_RECORD, '1, '1, '0);
        issue(CMD_RECORD, '0, '0, '0);
        // Same hash bits, context differs outside bits 4..35: one chain fills up
        for (int i = 0; i < 18; i++)
            issue(CMD_RECORD, 32'h1234, {12'(i), 32'h0, 4'(i)}, '0);
        issue(CMD_NONE, '1, '1, '1);
        issue(CMD_READ, '0, '0, '1);
        issue(CMD_TOTALS, '0, '0, '0);

        // Random bursts, with a full drain now and then
        for (int n = 0; n < 380; )
        begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++, n++) random_item();
            if ($urandom_range(0, 9) == 0)
            begin
                start <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            else
                rest($urandom_range(0, 6));
        end
        // Sweep the table at random strides so stored entries get read back
        for (int s = 0; s < TableSlotsDefault; s += 1 + $urandom_range(0, 3))
            issue(CMD_READ, '0, '0, SLOT_W'(s));
        issue(CMD_TOTALS, '0, '0, '0);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("hashed_flow_count_table_test passed");
        else
            $display("hashed_flow_count_table_test failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/hfct_pkg.sv
rtl/hfct_ctrl.sv
rtl/hfct_dp.sv
rtl/hashed_flow_count_table.sv
sim/hashed_flow_count_table_checker.sv
sim/hashed_flow_count_table_test.sv
